// File: hdl/assert_macros.svh
// Assertion macros shared by the verification checkers of this project.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: hdl/tmvg_pkg.sv
// Shared types, constants and helper functions of the torus vertex generator.
// No dependencies; used by the controller, the datapath and the top level.
package tmvg_pkg;

	// Default phase resolution in bits (one full turn is 2**PHASE_BITS).
	localparam int PHASE_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAJOR_RADIUS = 3'd0;
	localparam logic [2:0] REG_RING_RADIUS  = 3'd1;
	localparam logic [2:0] REG_SLICE_COUNT  = 3'd2;
	localparam logic [2:0] REG_ANGLE_STEP   = 3'd3;
	localparam logic [2:0] REG_PHI_START    = 3'd4;
	localparam logic [2:0] REG_UV_STEP      = 3'd5;

	// Configuration reset values.
	localparam logic [15:0] MAJOR_RADIUS_RST = 16'd512;
	localparam logic [15:0] RING_RADIUS_RST  = 16'd256;
	localparam logic [7:0]  SLICE_COUNT_RST  = 8'd16;
	localparam logic [15:0] ANGLE_STEP_RST   = 16'd4096;
	localparam logic [15:0] PHI_START_RST    = 16'd44307;
	localparam logic [19:0] UV_STEP_RST      = 20'd128;

	// Quarter-wave sine polynomial coefficients in unsigned Q30.
	localparam logic [30:0] PC1 = 31'd1686629713;
	localparam logic [30:0] PC3 = 31'd693598669;
	localparam logic [30:0] PC5 = 31'd85569306;
	localparam logic [30:0] PC7 = 31'd5026995;
	localparam logic [30:0] PC9 = 31'd172272;

	// Largest trig magnitude in Q1.15.
	localparam logic [16:0] TRIG_ONE = 17'd32768;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_ARG,
		OP_SQ,
		OP_HORN,
		OP_TFIN,
		OP_RLD,
		OP_RFIN,
		OP_YLD,
		OP_YFIN,
		OP_XLD,
		OP_XFIN,
		OP_ZLD,
		OP_ZFIN,
		OP_OUT,
		OP_COMMIT
	} op_t;

	// One command word: the operation and its operand select.
	typedef struct packed {
		op_t        op;
		logic [2:0] sel;
	} cmd_t;

	// Horner coefficient for step k, from the high-order end down.
	function automatic logic [30:0] horner_coef(input logic [1:0] k);
		logic [30:0] c;
		case (k)
			2'd0: c = PC7;
			2'd1: c = PC5;
			2'd2: c = PC3;
			default: c = PC1;
		endcase
		return c;
	endfunction

	// Color as red, green, blue bits for a column position modulo six.
	function automatic logic [2:0] color_lut(input logic [2:0] i);
		logic [2:0] c;
		case (i)
			3'd0: c = 3'd4;
			3'd1: c = 3'd2;
			3'd2: c = 3'd1;
			3'd3: c = 3'd5;
			3'd4: c = 3'd6;
			3'd5: c = 3'd5;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/tmvg_ctrl.sv
// Sequencer of the torus vertex generator: walks the micro-operations of one cell.
// Depends on tmvg_pkg for the command type.
module tmvg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output tmvg_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ARG,
		S_SQ,
		S_HORN,
		S_TFIN,
		S_RLD,
		S_RFIN,
		S_YLD,
		S_YFIN,
		S_XLD,
		S_XFIN,
		S_ZLD,
		S_ZFIN,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] e_q;
	logic [1:0] k_q;
	logic [1:0] j_q;
	logic       wait_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current step.
	always_comb begin
		cmd.op  = tmvg_pkg::OP_NONE;
		cmd.sel = 3'd0;
		if (!wait_q) begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd.op = tmvg_pkg::OP_START;
					end
				end
				S_ARG: begin
					cmd.op  = tmvg_pkg::OP_ARG;
					cmd.sel = e_q;
				end
				S_SQ: begin
					cmd.op = tmvg_pkg::OP_SQ;
				end
				S_HORN: begin
					cmd.op  = tmvg_pkg::OP_HORN;
					cmd.sel = {1'b0, k_q};
				end
				S_TFIN: begin
					cmd.op  = tmvg_pkg::OP_TFIN;
					cmd.sel = e_q;
				end
				S_RLD: begin
					cmd.op  = tmvg_pkg::OP_RLD;
					cmd.sel = {1'b0, j_q};
				end
				S_RFIN: begin
					cmd.op  = tmvg_pkg::OP_RFIN;
					cmd.sel = {1'b0, j_q};
				end
				S_YLD: begin
					cmd.op  = tmvg_pkg::OP_YLD;
					cmd.sel = {1'b0, j_q};
				end
				S_YFIN: begin
					cmd.op  = tmvg_pkg::OP_YFIN;
					cmd.sel = {1'b0, j_q};
				end
				S_XLD: begin
					cmd.op  = tmvg_pkg::OP_XLD;
					cmd.sel = {1'b0, j_q};
				end
				S_XFIN: begin
					cmd.op  = tmvg_pkg::OP_XFIN;
					cmd.sel = {1'b0, j_q};
				end
				S_ZLD: begin
					cmd.op  = tmvg_pkg::OP_ZLD;
					cmd.sel = {1'b0, j_q};
				end
				S_ZFIN: begin
					cmd.op  = tmvg_pkg::OP_ZFIN;
					cmd.sel = {1'b0, j_q};
				end
				S_OUT: begin
					if (!out_valid_q) begin
						cmd.op  = tmvg_pkg::OP_OUT;
						cmd.sel = {1'b0, j_q};
					end else if (out_ready) begin
						if (j_q == 2'd3) begin
							cmd.op = tmvg_pkg::OP_COMMIT;
						end else begin
							cmd.op  = tmvg_pkg::OP_OUT;
							cmd.sel = {1'b0, j_q + 2'd1};
						end
					end
				end
				default: begin
					cmd.op = tmvg_pkg::OP_NONE;
				end
			endcase
		end
	end

	// State and counters. A step that loads the multiplier is followed by an idle
	// wait state so that its product is registered before it is used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			e_q         <= 3'd0;
			k_q         <= 2'd0;
			j_q         <= 2'd0;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (wait_q) begin
			wait_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ARG;
						e_q     <= 3'd0;
					end
				end
				S_ARG: begin
					wait_q  <= 1'b1;
					state_q <= S_SQ;
				end
				S_SQ: begin
					wait_q  <= 1'b1;
					k_q     <= 2'd0;
					state_q <= S_HORN;
				end
				S_HORN: begin
					wait_q <= 1'b1;
					if (k_q == 2'd3) begin
						state_q <= S_TFIN;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_TFIN: begin
					if (e_q == 3'd7) begin
						j_q     <= 2'd0;
						state_q <= S_RLD;
					end else begin
						e_q     <= e_q + 3'd1;
						state_q <= S_ARG;
					end
				end
				S_RLD: begin
					wait_q  <= 1'b1;
					state_q <= S_RFIN;
				end
				S_RFIN: begin
					state_q <= S_YLD;
				end
				S_YLD: begin
					wait_q  <= 1'b1;
					state_q <= S_YFIN;
				end
				S_YFIN: begin
					if (j_q[0]) begin
						j_q     <= 2'd0;
						state_q <= S_XLD;
					end else begin
						j_q     <= 2'd1;
						state_q <= S_RLD;
					end
				end
				S_XLD: begin
					wait_q  <= 1'b1;
					state_q <= S_XFIN;
				end
				S_XFIN: begin
					state_q <= S_ZLD;
				end
				S_ZLD: begin
					wait_q  <= 1'b1;
					state_q <= S_ZFIN;
				end
				S_ZFIN: begin
					if (j_q == 2'd3) begin
						j_q     <= 2'd0;
						state_q <= S_OUT;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_XLD;
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						if (j_q == 2'd3) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/tmvg_dp.sv
// Datapath of the torus vertex generator: registers, mesh state, one shared
// multiplier and the vertex output register. Depends on tmvg_pkg.
module tmvg_dp #(
	parameter int PHASE_BITS = tmvg_pkg::PHASE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               restart,
	input  tmvg_pkg::cmd_t     cmd,
	output logic signed [17:0] pos_x,
	output logic signed [17:0] pos_y,
	output logic signed [17:0] pos_z,
	output logic [19:0]        tex_u,
	output logic [19:0]        tex_v,
	output logic [2:0]         color,
	output logic [17:0]        vertex_number,
	output logic               cell_last,
	output logic               mesh_last
);

	localparam int XSH = 32 - PHASE_BITS;
	localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS-2){1'b0}}};
	localparam logic [PHASE_BITS-2:0] QUARTER_ARG = {1'b1, {(PHASE_BITS-2){1'b0}}};

	// Configuration registers.
	logic [15:0] major_q;
	logic [15:0] ring_q;
	logic [7:0]  slice_q;
	logic [15:0] step_q;
	logic [15:0] phis_q;
	logic [19:0] uvs_q;

	// Mesh state.
	logic [PHASE_BITS-1:0] theta_q;
	logic [PHASE_BITS-1:0] phi_q;
	logic [19:0]           u_q;
	logic [19:0]           v_q;
	logic [7:0]            col_q;
	logic [7:0]            row_q;
	logic [2:0]            col6_q;
	logic [17:0]           vcnt_q;

	// Working registers of the cell computation.
	logic signed [32:0] ma_q;
	logic signed [32:0] mb_q;
	logic signed [65:0] prod_q;
	logic [30:0]        x_q;
	logic [30:0]        x2_q;
	logic               neg_q;
	logic signed [16:0] tv_q [8];
	logic signed [17:0] rad_q [2];
	logic signed [17:0] yv_q [2];
	logic signed [17:0] xo_q [4];
	logic signed [17:0] zo_q [4];

	// Output register.
	logic signed [17:0] pos_x_q;
	logic signed [17:0] pos_y_q;
	logic signed [17:0] pos_z_q;
	logic [19:0]        tex_u_q;
	logic [19:0]        tex_v_q;
	logic [2:0]         color_q;
	logic [17:0]        vnum_q;
	logic               cell_last_q;
	logic               mesh_last_q;

	// Next-cell values and end-of-row tests.
	logic [PHASE_BITS-1:0] step_p;
	logic [PHASE_BITS-1:0] phi1;
	logic [PHASE_BITS-1:0] theta1;
	logic [19:0]           u1;
	logic [19:0]           v1;
	logic [7:0]            col_inc;
	logic [7:0]            row_inc;
	logic                  col_end;
	logic                  row_end;

	assign step_p  = PHASE_BITS'(step_q);
	assign phi1    = phi_q + step_p;
	assign theta1  = theta_q + step_p;
	assign u1      = u_q + uvs_q;
	assign v1      = v_q + uvs_q;
	assign col_inc = col_q + 8'd1;
	assign row_inc = row_q + 8'd1;
	assign col_end = (col_inc == slice_q);
	assign row_end = (row_inc == slice_q);

	// Trig argument: pick the phase, shift cosine by a quarter turn, fold into
	// the first quadrant and scale to Q30.
	logic [PHASE_BITS-1:0] ph_sel;
	logic [PHASE_BITS-1:0] ph_adj;
	logic [1:0]            quad;
	logic [PHASE_BITS-3:0] frac;
	logic [PHASE_BITS-2:0] arg;
	logic [30:0]           x_arg;

	always_comb begin
		case (cmd.sel[2:1])
			2'd0: ph_sel = phi_q;
			2'd1: ph_sel = phi1;
			2'd2: ph_sel = theta_q;
			default: ph_sel = theta1;
		endcase
		ph_adj = ph_sel + (cmd.sel[0] ? QUARTER : '0);
		quad   = ph_adj[PHASE_BITS-1:PHASE_BITS-2];
		frac   = ph_adj[PHASE_BITS-3:0];
		arg    = quad[0] ? (QUARTER_ARG - {1'b0, frac}) : {1'b0, frac};
		x_arg  = {arg, {XSH{1'b0}}};
	end

	// Product scaling for the polynomial and the two rounding forms.
	logic [30:0]        prod_hi;
	logic [30:0]        hterm;
	logic [31:0]        tsum;
	logic [16:0]        tmag;
	logic [16:0]        tcap;
	logic signed [16:0] tval;
	logic signed [65:0] rsum;
	logic signed [17:0] rnd18;

	assign prod_hi = prod_q[60:30];
	assign hterm   = tmvg_pkg::horner_coef(cmd.sel[1:0]) - prod_hi;
	assign tsum    = {1'b0, prod_hi} + 32'd16384;
	assign tmag    = tsum[31:15];
	assign tcap    = (tmag > tmvg_pkg::TRIG_ONE) ? tmvg_pkg::TRIG_ONE : tmag;
	assign tval    = neg_q ? $signed(17'd0 - tcap) : $signed(tcap);
	assign rsum    = prod_q + 66'sd16384;
	assign rnd18   = $signed(rsum[32:15]);

	// Trig value read for the position products.
	logic [2:0] tv_idx;

	always_comb begin
		case (cmd.op)
			tmvg_pkg::OP_RLD: tv_idx = {1'b0, cmd.sel[0], 1'b1};
			tmvg_pkg::OP_YLD: tv_idx = {1'b0, cmd.sel[0], 1'b0};
			tmvg_pkg::OP_XLD: tv_idx = {1'b1, cmd.sel[1] ^ cmd.sel[0], 1'b1};
			tmvg_pkg::OP_ZLD: tv_idx = {1'b1, cmd.sel[1] ^ cmd.sel[0], 1'b0};
			default: tv_idx = 3'd0;
		endcase
	end

	// Configuration writes and mesh state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q <= tmvg_pkg::MAJOR_RADIUS_RST;
			ring_q  <= tmvg_pkg::RING_RADIUS_RST;
			slice_q <= tmvg_pkg::SLICE_COUNT_RST;
			step_q  <= tmvg_pkg::ANGLE_STEP_RST;
			phis_q  <= tmvg_pkg::PHI_START_RST;
			uvs_q   <= tmvg_pkg::UV_STEP_RST;
			theta_q <= '0;
			phi_q   <= PHASE_BITS'(tmvg_pkg::PHI_START_RST);
			u_q     <= '0;
			v_q     <= '0;
			col_q   <= '0;
			row_q   <= '0;
			col6_q  <= '0;
			vcnt_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					tmvg_pkg::REG_MAJOR_RADIUS: major_q <= cfg_data[15:0];
					tmvg_pkg::REG_RING_RADIUS:  ring_q  <= cfg_data[15:0];
					tmvg_pkg::REG_SLICE_COUNT:  slice_q <= cfg_data[7:0];
					tmvg_pkg::REG_ANGLE_STEP:   step_q  <= cfg_data[15:0];
					tmvg_pkg::REG_PHI_START:    phis_q  <= cfg_data[15:0];
					tmvg_pkg::REG_UV_STEP:      uvs_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == tmvg_pkg::OP_START && restart) begin
				theta_q <= '0;
				phi_q   <= PHASE_BITS'(phis_q);
				u_q     <= '0;
				v_q     <= '0;
				col_q   <= '0;
				row_q   <= '0;
				col6_q  <= '0;
				vcnt_q  <= '0;
			end else if (cmd.op == tmvg_pkg::OP_COMMIT) begin
				phi_q  <= phi1;
				u_q    <= u1;
				vcnt_q <= vcnt_q + 18'd4;
				if (col_end) begin
					col_q  <= '0;
					col6_q <= '0;
					if (row_end) begin
						row_q   <= '0;
						theta_q <= '0;
						v_q     <= '0;
						vcnt_q  <= '0;
					end else begin
						row_q   <= row_inc;
						theta_q <= theta1;
						v_q     <= v1;
					end
				end else begin
					col_q <= col_inc;
					// The counter wraps through zero when it runs past 255.
					if (col_q == 8'hFF || col6_q == 3'd5) begin
						col6_q <= '0;
					end else begin
						col6_q <= col6_q + 3'd1;
					end
				end
			end
		end
	end

	// Shared multiplier and the micro-operations of one cell.
	always_ff @(posedge clk) begin
		prod_q <= ma_q * mb_q;
		case (cmd.op)
			tmvg_pkg::OP_ARG: begin
				x_q   <= x_arg;
				neg_q <= quad[1];
				ma_q  <= $signed({2'b00, x_arg});
				mb_q  <= $signed({2'b00, x_arg});
			end
			tmvg_pkg::OP_SQ: begin
				x2_q <= prod_hi;
				ma_q <= $signed({2'b00, prod_hi});
				mb_q <= $signed({2'b00, tmvg_pkg::PC9});
			end
			tmvg_pkg::OP_HORN: begin
				ma_q <= (cmd.sel[1:0] == 2'd3) ? $signed({2'b00, x_q}) : $signed({2'b00, x2_q});
				mb_q <= $signed({2'b00, hterm});
			end
			tmvg_pkg::OP_TFIN: begin
				tv_q[cmd.sel] <= tval;
			end
			tmvg_pkg::OP_RLD, tmvg_pkg::OP_YLD: begin
				ma_q <= $signed({17'd0, ring_q});
				mb_q <= 33'(tv_q[tv_idx]);
			end
			tmvg_pkg::OP_RFIN: begin
				rad_q[cmd.sel[0]] <= $signed({2'b00, major_q}) + rnd18;
			end
			tmvg_pkg::OP_YFIN: begin
				yv_q[cmd.sel[0]] <= rnd18;
			end
			tmvg_pkg::OP_XLD, tmvg_pkg::OP_ZLD: begin
				ma_q <= 33'(rad_q[cmd.sel[1]]);
				mb_q <= 33'(tv_q[tv_idx]);
			end
			tmvg_pkg::OP_XFIN: begin
				xo_q[cmd.sel[1:0]] <= rnd18;
			end
			tmvg_pkg::OP_ZFIN: begin
				zo_q[cmd.sel[1:0]] <= rnd18;
			end
			tmvg_pkg::OP_OUT: begin
				pos_x_q     <= xo_q[cmd.sel[1:0]];
				pos_y_q     <= yv_q[cmd.sel[1]];
				pos_z_q     <= zo_q[cmd.sel[1:0]];
				tex_u_q     <= cmd.sel[1] ? u1 : u_q;
				tex_v_q     <= (cmd.sel[1] ^ cmd.sel[0]) ? v1 : v_q;
				color_q     <= tmvg_pkg::color_lut(col6_q);
				vnum_q      <= vcnt_q + 18'(cmd.sel[1:0]);
				cell_last_q <= (cmd.sel[1:0] == 2'd3);
				mesh_last_q <= (cmd.sel[1:0] == 2'd3) && col_end && row_end;
			end
			default: ;
		endcase
	end

	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign pos_z         = pos_z_q;
	assign tex_u         = tex_u_q;
	assign tex_v         = tex_v_q;
	assign color         = color_q;
	assign vertex_number = vnum_q;
	assign cell_last     = cell_last_q;
	assign mesh_last     = mesh_last_q;

endmodule

// File: hdl/torus_mesh_vertex_generator.sv
// Torus mesh vertex generator. Each accepted word requests the next quad cell
// and returns four vertex words: bottom-left, top-left, top-right, bottom-right.
// The work of one cell is paced by the single shared 33x33 multiplier: eight
// sine and cosine evaluations of six products each, then four radial and
// height products and eight x and z products, each product followed by a wait
// state while it is registered. A new cell is accepted only after its last
// vertex is taken. The configuration port is always ready; write it only while
// the block is idle.
// Depends on tmvg_pkg, tmvg_ctrl and tmvg_dp.
module torus_mesh_vertex_generator #(
	parameter int PHASE_BITS = tmvg_pkg::PHASE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] pos_x,
	output logic signed [17:0] pos_y,
	output logic signed [17:0] pos_z,
	output logic [19:0]        tex_u,
	output logic [19:0]        tex_v,
	output logic [2:0]         color,
	output logic [17:0]        vertex_number,
	output logic               cell_last,
	output logic               mesh_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);

	tmvg_pkg::cmd_t cmd;

	// Register writes are never stalled.
	assign cfg_ready = 1'b1;

	// Sequencer.
	tmvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Arithmetic, state and output register.
	tmvg_dp #(
		.PHASE_BITS (PHASE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.restart       (restart),
		.cmd           (cmd),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.tex_u         (tex_u),
		.tex_v         (tex_v),
		.color         (color),
		.vertex_number (vertex_number),
		.cell_last     (cell_last),
		.mesh_last     (mesh_last)
	);

endmodule

// File: hdl/tmvg_checker.sv
// Port-level checks of the torus vertex generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tmvg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [17:0] pos_x,
	input logic [17:0]        vertex_number,
	input logic               cell_last,
	input logic               mesh_last
);

	// A cell in flight blocks the next request.
	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// Vertices are only offered while a cell is in flight.
	`ASSERT_IMPL(a_out_only_when_busy, out_valid, !in_ready)

	// The mesh ends only on the last vertex of a cell.
	`ASSERT_IMPL(a_mesh_on_cell_end, out_valid && mesh_last, cell_last)

	// A stalled vertex word holds.
	`ASSERT_NEXT(a_hold_out, out_valid && !out_ready,
		out_valid && $stable(pos_x) && $stable(vertex_number))

endmodule

bind torus_mesh_vertex_generator tmvg_checker u_tmvg_checker (.*);

// File: tb/torus_mesh_vertex_generator_tb.sv
// Self-checking testbench for the torus mesh vertex generator.
// Predicts each cell's four vertex words in fixed point and compares them field by field.
// Depends on tmvg_pkg and torus_mesh_vertex_generator.
module torus_mesh_vertex_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Vertex word as predicted.
	typedef struct packed {
		logic [17:0] x;
		logic [17:0] y;
		logic [17:0] z;
		logic [19:0] u;
		logic [19:0] v;
		logic [2:0]  rgb;
		logic [17:0] num;
		logic        c_last;
		logic        m_last;
	} vertex_t;

	localparam int CYCLE_LIMIT = 1200000;

	// Register index with no register behind it.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [17:0] pos_x, pos_y, pos_z;
	logic [19:0] tex_u, tex_v;
	logic [2:0] color;
	logic [17:0] vertex_number;
	logic cell_last, mesh_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = 3'd0;
	logic [19:0] cfg_data = 20'd0;

	torus_mesh_vertex_generator uut (.*);

	// Clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the configuration and the mesh state.
	logic [15:0] m_major, m_ring, m_step, m_phi0;
	logic [7:0]  m_slices;
	logic [19:0] m_uvstep;
	logic [15:0] theta_ph, phi_ph;
	logic [19:0] u_acc, v_acc;
	logic [7:0]  col_cnt, row_cnt;
	logic [17:0] vert_cnt;

	vertex_t expected_vertices[$];
	int errors = 0;
	int cycles = 0;
	bit long_hold = 1'b0;

	// Sine of a quarter-turn fraction in Q1.15.
	function automatic longint quarter_sin(input longint f);
		longint unsigned x, x2, t, s, r;
		x = longint'(f) << 16;
		x2 = (x * x) >> 30;
		t = 172272;
		t = 64'd5026995 - ((x2 * t) >> 30);
		t = 64'd85569306 - ((x2 * t) >> 30);
		t = 64'd693598669 - ((x2 * t) >> 30);
		t = 64'd1686629713 - ((x2 * t) >> 30);
		s = (x * t) >> 30;
		r = (s + 16384) >> 15;
		if (r > 32768)
			r = 32768;
		return longint'(r);
	endfunction

	function automatic longint sin_of(input logic [15:0] p);
		longint v;
		v = p[14] ? quarter_sin(16384 - p[13:0]) : quarter_sin(p[13:0]);
		return p[15] ? -v : v;
	endfunction

	function automatic longint cos_of(input logic [15:0] p);
		return sin_of(p + 16'd16384);
	endfunction

	// Rounds a Q15-scaled product to nearest, ties upward.
	function automatic longint round_q15(input longint v);
		return (v + 16384) >>> 15;
	endfunction

	function automatic vertex_t make_vertex(input longint pc, ps, tc, ts,
			input logic [19:0] u, v, input logic [2:0] rgb, input int k, input bit m_end);
		vertex_t w;
		longint radial;
		radial = longint'(m_major) + round_q15(longint'(m_ring) * pc);
		w.x = 18'(round_q15(radial * tc));
		w.z = 18'(round_q15(radial * ts));
		w.y = 18'(round_q15(longint'(m_ring) * ps));
		w.u = u;
		w.v = v;
		w.rgb = rgb;
		w.num = vert_cnt + 18'(k);
		w.c_last = (k == 3);
		w.m_last = (k == 3) && m_end;
		return w;
	endfunction

	// Appends one predicted vertex word at the tail of the expected queue.
	function automatic void expect_vertex(input vertex_t w);
		expected_vertices = {expected_vertices, w};
	endfunction

	function automatic void clear_mesh();
		theta_ph = 0;
		phi_ph = m_phi0;
		u_acc = 0;
		v_acc = 0;
		col_cnt = 0;
		row_cnt = 0;
		vert_cnt = 0;
	endfunction

	// Predicts the four vertex words of one cell and advances the mesh state.
	function automatic void predict_cell(input bit rs);
		logic [15:0] phi1, th1;
		logic [19:0] u1, v1;
		logic [2:0] rgb;
		longint pc0, ps0, pc1, ps1, tc0, ts0, tc1, ts1;
		bit col_end, row_end;
		if (rs)
			clear_mesh();
		phi1 = phi_ph + m_step;
		th1 = theta_ph + m_step;
		pc0 = cos_of(phi_ph);
		ps0 = sin_of(phi_ph);
		pc1 = cos_of(phi1);
		ps1 = sin_of(phi1);
		tc0 = cos_of(theta_ph);
		ts0 = sin_of(theta_ph);
		tc1 = cos_of(th1);
		ts1 = sin_of(th1);
		u1 = u_acc + m_uvstep;
		v1 = v_acc + m_uvstep;
		rgb = tmvg_pkg::color_lut(3'(col_cnt % 6));
		col_end = (col_cnt + 8'd1) == m_slices;
		row_end = (row_cnt + 8'd1) == m_slices;
		expect_vertex(make_vertex(pc0, ps0, tc0, ts0, u_acc, v_acc, rgb, 0,
			col_end && row_end));
		expect_vertex(make_vertex(pc0, ps0, tc1, ts1, u_acc, v1, rgb, 1,
			col_end && row_end));
		expect_vertex(make_vertex(pc1, ps1, tc1, ts1, u1, v1, rgb, 2,
			col_end && row_end));
		expect_vertex(make_vertex(pc1, ps1, tc0, ts0, u1, v_acc, rgb, 3,
			col_end && row_end));
		phi_ph = phi1;
		u_acc = u1;
		vert_cnt = vert_cnt + 18'd4;
		if (col_end) begin
			col_cnt = 0;
			if (row_end) begin
				row_cnt = 0;
				theta_ph = 0;
				v_acc = 0;
				vert_cnt = 0;
			end else begin
				row_cnt = row_cnt + 8'd1;
				theta_ph = th1;
				v_acc = v1;
			end
		end else begin
			col_cnt = col_cnt + 8'd1;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [19:0] got, exp);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
	endtask

	// Receiver stall pattern, with one long hold-off when requested.
	always @(posedge clk) begin
		if (long_hold)
			out_ready <= 1'b0;
		else if (cycles % 400 < 150)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// Result checker and cycle limit.
	always @(posedge clk) begin
		vertex_t w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("torus_mesh_vertex_generator_tb: FAIL");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				report_mismatch("unexpected word", 20'd0, 20'd0);
			end else begin
				w = expected_vertices.pop_front();
				if (pos_x !== w.x) report_mismatch("pos_x", 20'(pos_x), 20'(w.x));
				if (pos_y !== w.y) report_mismatch("pos_y", 20'(pos_y), 20'(w.y));
				if (pos_z !== w.z) report_mismatch("pos_z", 20'(pos_z), 20'(w.z));
				if (tex_u !== w.u) report_mismatch("tex_u", tex_u, w.u);
				if (tex_v !== w.v) report_mismatch("tex_v", tex_v, w.v);
				if (color !== w.rgb) report_mismatch("color", 20'(color), 20'(w.rgb));
				if (vertex_number !== w.num)
					report_mismatch("vertex_number", 20'(vertex_number), 20'(w.num));
				if (cell_last !== w.c_last)
					report_mismatch("cell_last", 20'(cell_last), 20'(w.c_last));
				if (mesh_last !== w.m_last)
					report_mismatch("mesh_last", 20'(mesh_last), 20'(w.m_last));
			end
		end
	end

	// Sends one cell request word and predicts its vertices on acceptance.
	task automatic send_cell(input bit rs);
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		predict_cell(rs);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sends a burst-shaped stream of cells with random gaps.
	task automatic send_stream(input int count, input int restart_odds);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			send_cell($urandom_range(0, restart_odds) == 0);
			if (burst == 0) begin
				repeat ($urandom_range(0, 6)) @(posedge clk);
				burst = $urandom_range(1, 5);
			end else begin
				burst--;
			end
		end
	endtask

	task automatic drain();
		while (expected_vertices.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tmvg_pkg::REG_MAJOR_RADIUS: m_major = data[15:0];
			tmvg_pkg::REG_RING_RADIUS:  m_ring = data[15:0];
			tmvg_pkg::REG_SLICE_COUNT:  m_slices = data[7:0];
			tmvg_pkg::REG_ANGLE_STEP:   m_step = data[15:0];
			tmvg_pkg::REG_PHI_START:    m_phi0 = data[15:0];
			tmvg_pkg::REG_UV_STEP:      m_uvstep = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [15:0] maj, ring, step, phi0,
			input logic [7:0] sl, input logic [19:0] uv);
		write_reg(tmvg_pkg::REG_MAJOR_RADIUS, 20'(maj));
		write_reg(tmvg_pkg::REG_RING_RADIUS, 20'(ring));
		write_reg(tmvg_pkg::REG_SLICE_COUNT, 20'(sl));
		write_reg(tmvg_pkg::REG_ANGLE_STEP, 20'(step));
		write_reg(tmvg_pkg::REG_PHI_START, 20'(phi0));
		write_reg(tmvg_pkg::REG_UV_STEP, uv);
	endtask

	// Reset values and a restart in the middle of a row.
	task automatic test_defaults();
		for (int i = 0; i < 6; i++)
			send_cell(i == 4);
		drain();
	endtask

	// Extreme register settings, small meshes with mesh ends, degenerate step.
	task automatic test_extremes();
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 20'hFFFFF);
		for (int i = 0; i < 4; i++)
			send_cell(i == 0);
		drain();
		write_all(16'd0, 16'd0, 16'd1, 16'd0, 8'd2, 20'd0);
		for (int i = 0; i < 5; i++)
			send_cell(i == 0);
		drain();
		// Zero slice count acts as 256; zero step keeps the phases still.
		write_reg(tmvg_pkg::REG_SLICE_COUNT, 20'd0);
		write_reg(tmvg_pkg::REG_ANGLE_STEP, 20'd0);
		write_reg(REG_UNUSED, 20'hABCDE);
		for (int i = 0; i < 4; i++)
			send_cell(1'b0);
		drain();
		// Lowered slice count while mid-row.
		write_reg(tmvg_pkg::REG_SLICE_COUNT, 20'd2);
		write_reg(tmvg_pkg::REG_ANGLE_STEP, 20'd9000);
		for (int i = 0; i < 6; i++)
			send_cell(1'b0);
		drain();
	endtask

	// Long receiver hold-off while the sender keeps offering cells.
	task automatic test_backpressure();
		write_all(16'd700, 16'd300, 16'd5000, 16'd12345, 8'd3, 20'd333);
		long_hold = 1'b1;
		fork
			send_stream(4, 3);
			begin
				repeat (2000) @(posedge clk);
				long_hold = 1'b0;
			end
		join
		drain();
	endtask

	// Random cells across several configurations.
	task automatic test_random();
		for (int ph = 0; ph < 4; ph++) begin
			write_all(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
				16'($urandom), 8'($urandom_range(1, 6)), 20'($urandom));
			send_stream(20, 9);
			drain();
		end
	endtask

	initial begin
		m_major = tmvg_pkg::MAJOR_RADIUS_RST;
		m_ring = tmvg_pkg::RING_RADIUS_RST;
		m_step = tmvg_pkg::ANGLE_STEP_RST;
		m_phi0 = tmvg_pkg::PHI_START_RST;
		m_uvstep = tmvg_pkg::UV_STEP_RST;
		m_slices = tmvg_pkg::SLICE_COUNT_RST;
		clear_mesh();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_defaults();
		test_extremes();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("torus_mesh_vertex_generator_tb: PASS");
		else
			$display("torus_mesh_vertex_generator_tb: FAIL");
		$finish;
	end

endmodule
